/* hw/rtl/hrlp_pkg.sv */
// Package for the hex record line parser: status codes and the hex digit decode.
// Used by hex_record_line_parser; depends on nothing else.
package hrlp_pkg;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_DELIM = 2'd1,
		STATUS_BAD_DIGIT = 2'd2,
		STATUS_BAD_SUM   = 2'd3
	} status_t;

	localparam logic [7:0] DELIM_CHAR   = 8'h3a;
	localparam int unsigned HEADER_BYTES = 4;
	localparam int unsigned FRAME_BYTES  = 5;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} nibble_t;

	// Decodes one ASCII character into a nibble; upper and lower case letters are accepted.
	function automatic nibble_t decode_nibble(input logic [7:0] c);
		nibble_t n;
		n.valid = 1'b1;
		n.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n.value = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			n.value = 4'(c - 8'h57);
		end else begin
			n.valid = 1'b0;
		end
		return n;
	endfunction

endpackage

/* hw/rtl/hex_record_line_parser.sv */
// Hex record line parser: one character beat in, at most one result beat out.
// An accepted input beat is held in the input register, and its result moves on to the
// output register when the output is not stalled.
// Throughput: one input beat per cycle; the output register frees the input side while
// a result waits, and a stall on the output holds the input stage only when it is full.
// Reset clears the line state, so the first beat after reset starts a new line.
// Depends on hrlp_pkg.
module hex_record_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  data_index,
	output logic [1:0]  status,
	output logic [7:0]  record_type,
	output logic [7:0]  data_length,
	output logic [15:0] load_address,
	output logic        line_done
);
	import hrlp_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;

	// Line state
	logic        first_seen_q;
	logic        delim_bad_q;
	logic        digit_bad_q;
	logic        half_pending_q;
	logic [3:0]  high_nibble_q;
	logic [8:0]  pair_count_q;
	logic [7:0]  sum_q;
	logic [31:0] header_q;

	logic        first_seen_d;
	logic        delim_bad_d;
	logic        digit_bad_d;
	logic        half_pending_d;
	logic [3:0]  high_nibble_d;
	logic [8:0]  pair_count_d;
	logic [7:0]  sum_d;
	logic [31:0] header_d;

	// Result register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  data_byte_q;
	logic [7:0]  data_index_q;
	status_t     status_q;
	logic [7:0]  record_type_q;
	logic [7:0]  data_length_q;
	logic [15:0] load_address_q;

	logic        advance;
	logic        has_result;
	logic        res_kind;
	logic [7:0]  res_byte;
	logic [7:0]  res_index;
	status_t     res_status;
	logic [7:0]  res_type;
	logic [7:0]  res_length;
	logic [15:0] res_address;

	nibble_t     nib;
	logic [3:0]  nib_value;
	logic [7:0]  new_byte;
	logic [8:0]  data_pos;
	logic [7:0]  cur_length;

	// The stage moves whenever the result register is empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			eol_s1  <= end_of_line;
		end
	end

	assign nib        = decode_nibble(char_s1);
	assign nib_value  = nib.valid ? nib.value : 4'd0;
	assign new_byte   = {high_nibble_q, nib_value};
	assign data_pos   = pair_count_q - 9'(HEADER_BYTES);
	assign cur_length = header_q[31:24];

	always_comb begin
		first_seen_d   = first_seen_q;
		delim_bad_d    = delim_bad_q;
		digit_bad_d    = digit_bad_q;
		half_pending_d = half_pending_q;
		high_nibble_d  = high_nibble_q;
		pair_count_d   = pair_count_q;
		sum_d          = sum_q;
		header_d       = header_q;

		has_result  = 1'b0;
		res_kind    = 1'b0;
		res_byte    = 8'd0;
		res_index   = 8'd0;
		res_status  = STATUS_OK;
		res_type    = 8'd0;
		res_length  = 8'd0;
		res_address = 16'd0;

		if (eol_s1) begin
			has_result  = 1'b1;
			res_kind    = 1'b1;
			res_type    = header_q[7:0];
			res_length  = cur_length;
			res_address = header_q[23:8];
			if (!first_seen_q || delim_bad_q) begin
				res_status = STATUS_BAD_DELIM;
			end else if (digit_bad_q || half_pending_q ||
				({1'b0, pair_count_q} < ({2'b00, cur_length} + 10'(FRAME_BYTES)))) begin
				res_status = STATUS_BAD_DIGIT;
			end else if (sum_q != 8'd0) begin
				res_status = STATUS_BAD_SUM;
			end else begin
				res_status = STATUS_OK;
			end
			first_seen_d   = 1'b0;
			delim_bad_d    = 1'b0;
			digit_bad_d    = 1'b0;
			half_pending_d = 1'b0;
			high_nibble_d  = 4'd0;
			pair_count_d   = 9'd0;
			sum_d          = 8'd0;
			header_d       = 32'd0;
		end else if (!first_seen_q) begin
			first_seen_d = 1'b1;
			delim_bad_d  = (char_s1 != DELIM_CHAR);
		end else begin
			if (!nib.valid) begin
				digit_bad_d = 1'b1;
			end
			if (!half_pending_q) begin
				high_nibble_d  = nib_value;
				half_pending_d = 1'b1;
			end else begin
				half_pending_d = 1'b0;
				sum_d          = sum_q + new_byte;
				if (pair_count_q != '1) begin
					pair_count_d = pair_count_q + 9'd1;
				end
				case (pair_count_q)
					9'd0:    header_d[31:24] = new_byte;
					9'd1:    header_d[23:16] = new_byte;
					9'd2:    header_d[15:8]  = new_byte;
					9'd3:    header_d[7:0]   = new_byte;
					default: begin
						// Bytes past the header are data while inside the length.
						if (data_pos < {1'b0, cur_length}) begin
							has_result = 1'b1;
							res_byte   = new_byte;
							res_index  = data_pos[7:0];
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seen_q   <= 1'b0;
			delim_bad_q    <= 1'b0;
			digit_bad_q    <= 1'b0;
			half_pending_q <= 1'b0;
			high_nibble_q  <= 4'd0;
			pair_count_q   <= 9'd0;
			sum_q          <= 8'd0;
			header_q       <= 32'd0;
			out_valid_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && has_result;
			if (valid_s1) begin
				first_seen_q   <= first_seen_d;
				delim_bad_q    <= delim_bad_d;
				digit_bad_q    <= digit_bad_d;
				half_pending_q <= half_pending_d;
				high_nibble_q  <= high_nibble_d;
				pair_count_q   <= pair_count_d;
				sum_q          <= sum_d;
				header_q       <= header_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && has_result) begin
			kind_q         <= res_kind;
			data_byte_q    <= res_byte;
			data_index_q   <= res_index;
			status_q       <= res_status;
			record_type_q  <= res_type;
			data_length_q  <= res_length;
			load_address_q <= res_address;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_byte_q;
	assign data_index   = data_index_q;
	assign status       = status_q;
	assign record_type  = record_type_q;
	assign data_length  = data_length_q;
	assign load_address = load_address_q;
	assign line_done    = kind_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for hex_record_line_parser: character beats in, data and
// line status beats out, checked against a predictor kept in this file.
// Depends on hrlp_pkg and the hex_record_line_parser RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hrlp_pkg::*;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic [8:0] BYTE_COUNT_MAX = 9'd511;

	typedef logic [7:0] octet_q_t [$];

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  data_index;
		status_t     status;
		logic [7:0]  record_type;
		logic [7:0]  data_length;
		logic [15:0] load_address;
		logic        line_done;
	} line_result_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_SHORT,
		FLAW_ODD,
		FLAW_DIGIT,
		FLAW_DELIM
	} flaw_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = 8'h00;
	logic        end_of_line = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [7:0]  data_index;
	logic [1:0]  status;
	logic [7:0]  record_type;
	logic [7:0]  data_length;
	logic [15:0] load_address;
	logic        line_done;

	// Predictor state for the line in progress.
	logic        line_open;
	logic        delim_wrong;
	logic        digit_wrong;
	logic        nibble_held;
	logic [3:0]  upper_nibble;
	logic [8:0]  bytes_done;
	logic [7:0]  byte_sum;
	logic [7:0]  hdr_length;
	logic [15:0] hdr_address;
	logic [7:0]  hdr_type;

	line_result_t results_due [$];
	int          error_count = 0;
	int unsigned beats_sent = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b0;
	int          hold_cycles = 0;

	hex_record_line_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_in      (char_in),
		.end_of_line  (end_of_line),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.data_index   (data_index),
		.status       (status),
		.record_type  (record_type),
		.data_length  (data_length),
		.load_address (load_address),
		.line_done    (line_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		error_count++;
		if (error_count <= 40) begin
			$display("ERROR at %0t: %s", $time, what);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Returns the digit value in the low bits and a set top bit for a non-hex character.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
		if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
		if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'("0" + v);
		return ($urandom_range(0, 1) == 0) ? 8'("A" + v - 4'd10) : 8'("a" + v - 4'd10);
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		logic [4:0] n;
		do begin
			c = 8'($urandom_range(0, 255));
			n = hex_nibble(c);
		end while (!n[4]);
		return c;
	endfunction

	function automatic octet_q_t to_octets(input string s);
		octet_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	task automatic clear_line_state();
		line_open    = 1'b0;
		delim_wrong  = 1'b0;
		digit_wrong  = 1'b0;
		nibble_held  = 1'b0;
		upper_nibble = 4'd0;
		bytes_done   = 9'd0;
		byte_sum     = 8'd0;
		hdr_length   = 8'd0;
		hdr_address  = 16'd0;
		hdr_type     = 8'd0;
	endtask

	// Updates the line state for one accepted beat and queues the result it causes.
	task automatic absorb_beat(input logic [7:0] c, input logic eol);
		line_result_t r;
		logic [4:0]   nib;
		logic [7:0]   b;
		int unsigned  pos;
		r = '0;
		if (eol) begin
			r.kind = KIND_STATUS;
			r.line_done = 1'b1;
			if (!line_open || delim_wrong) begin
				r.status = STATUS_BAD_DELIM;
			end else if (digit_wrong || nibble_held ||
					int'(bytes_done) < int'(hdr_length) + int'(FRAME_BYTES)) begin
				r.status = STATUS_BAD_DIGIT;
			end else if (byte_sum != 8'd0) begin
				r.status = STATUS_BAD_SUM;
			end else begin
				r.status = STATUS_OK;
			end
			r.record_type  = hdr_type;
			r.data_length  = hdr_length;
			r.load_address = hdr_address;
			results_due.push_back(r);
			clear_line_state();
		end else if (!line_open) begin
			line_open = 1'b1;
			delim_wrong = (c != DELIM_CHAR);
		end else begin
			nib = hex_nibble(c);
			// A bad character still pairs up, as a zero digit.
			if (nib[4]) begin
				digit_wrong = 1'b1;
				nib = 5'd0;
			end
			if (!nibble_held) begin
				upper_nibble = nib[3:0];
				nibble_held = 1'b1;
			end else begin
				nibble_held = 1'b0;
				b = {upper_nibble, nib[3:0]};
				pos = bytes_done;
				byte_sum = byte_sum + b;
				if (bytes_done != BYTE_COUNT_MAX) bytes_done = bytes_done + 9'd1;
				if (pos < HEADER_BYTES) begin
					case (pos)
						0: hdr_length = b;
						1: hdr_address[15:8] = b;
						2: hdr_address[7:0] = b;
						default: hdr_type = b;
					endcase
				end else if (pos - HEADER_BYTES < hdr_length) begin
					r.kind = KIND_DATA;
					r.data_byte = b;
					r.data_index = 8'(pos - HEADER_BYTES);
					results_due.push_back(r);
				end
			end
		end
	endtask

	// Offers one beat, holding it until accepted; with gaps_on, bursts are broken by random gaps.
	task automatic send_beat(input logic [7:0] c, input logic eol);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 7);
			burst_left = $urandom_range(1, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		in_valid    <= 1'b1;
		char_in     <= c;
		end_of_line <= eol;
		do @(posedge clk); while (in_stall);
		absorb_beat(c, eol);
		beats_sent++;
	endtask

	task automatic send_text(input octet_q_t text);
		foreach (text[i]) send_beat(text[i], 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Builds a record with a correct checksum, appends zero-sum pairs past the checksum,
	// then damages it as asked.
	task automatic send_record(input int unsigned len, input flaw_t flaw,
			input int unsigned extra_pairs);
		octet_q_t    bytes;
		octet_q_t    text;
		logic [7:0]  sum;
		logic [7:0]  v;
		int unsigned cut;
		int unsigned spot;
		bytes.push_back(8'(len));
		bytes.push_back(8'($urandom_range(0, 255)));
		bytes.push_back(8'($urandom_range(0, 255)));
		bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 5)));
		repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
		sum = 8'd0;
		foreach (bytes[i]) sum = sum + bytes[i];
		bytes.push_back(8'(8'd0 - sum));
		if (flaw == FLAW_SUM) bytes[bytes.size() - 1] ^= 8'($urandom_range(1, 255));
		repeat (extra_pairs) begin
			v = 8'($urandom_range(0, 255));
			bytes.push_back(v);
			bytes.push_back(8'(8'd0 - v));
		end
		text.push_back(DELIM_CHAR);
		foreach (bytes[i]) begin
			text.push_back(hex_char(bytes[i][7:4]));
			text.push_back(hex_char(bytes[i][3:0]));
		end
		case (flaw)
			FLAW_SHORT: begin
				cut = $urandom_range(0, bytes.size() - 1);
				text = text[0:2 * cut];
			end
			FLAW_ODD: text.pop_back();
			FLAW_DIGIT: begin
				spot = $urandom_range(1, text.size() - 1);
				text[spot] = non_hex_char();
			end
			FLAW_DELIM: begin
				text[0] = 8'($urandom_range(0, 255));
				if (text[0] == DELIM_CHAR) text[0] ^= 8'h01;
			end
			default: ;
		endcase
		send_text(text);
	endtask

	task automatic test_directed_lines();
		gaps_on = 1'b0;
		// Terminator alone, with a character that must be ignored.
		send_beat(8'hff, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'h00, 1'b1);
		// Good one-byte record in mixed case.
		send_text(to_octets(":01ABcd00eF98"));
		send_text(to_octets(":0G1"));
		send_text(to_octets(":F"));
	endtask

	task automatic test_long_lines();
		gaps_on = 1'b1;
		send_record(255, FLAW_NONE, 0);
		// More bytes than the byte counter can hold.
		send_record(2, FLAW_NONE, 255);
	endtask

	task automatic test_output_hold();
		gaps_on = 1'b0;
		hold_cycles = 400;
		repeat (3) send_record(16, FLAW_NONE, 0);
	endtask

	task automatic test_random_lines();
		int unsigned start;
		int unsigned pick;
		int unsigned len;
		flaw_t       flaw;
		octet_q_t    noise;
		start = beats_sent;
		while (beats_sent - start < 250) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				noise.delete();
				if ($urandom_range(0, 1) == 0) noise.push_back(DELIM_CHAR);
				repeat ($urandom_range(0, 10)) noise.push_back(8'($urandom_range(0, 255)));
				send_text(noise);
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
				flaw = (pick < 60) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
				send_record(len, flaw,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
			end
		end
	endtask

	// Receiver: stall pattern changes every so often; a requested hold overrides it.
	initial begin
		stall_mode_t mode;
		int          left;
		mode = STALL_NONE;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				if (left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					left = $urandom_range(10, 150);
				end
				left--;
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= (left % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		line_result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (results_due.size() == 0) begin
				flag_mismatch("result beat with nothing expected");
			end else begin
				want = results_due.pop_front();
				check_field("kind", 16'(kind), 16'(want.kind));
				check_field("data_byte", 16'(data_byte), 16'(want.data_byte));
				check_field("data_index", 16'(data_index), 16'(want.data_index));
				check_field("status", 16'(status), 16'(want.status));
				check_field("record_type", 16'(record_type), 16'(want.record_type));
				check_field("data_length", 16'(data_length), 16'(want.data_length));
				check_field("load_address", load_address, want.load_address);
				check_field("line_done", 16'(line_done), 16'(want.line_done));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		clear_line_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		test_long_lines();
		test_output_hold();
		test_random_lines();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
